FILE: rtl/core/rse_pkg.sv
`timescale 1ns / 1ps

package rse_pkg;

  localparam int PRICE_W       = 32;
  localparam int CNT_W         = 17;
  localparam int TOT_W         = CNT_W + 2;
  localparam int LOG_FRAC_BITS = 16;
  localparam int EXP_W         = 5;
  localparam int LOG_W         = EXP_W + LOG_FRAC_BITS;
  localparam int MANT_BITS     = 30;
  localparam int MANT_W        = MANT_BITS + 1;
  localparam int MUL_W         = MANT_W;
  localparam int PROD_W        = TOT_W + LOG_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int ENT_FRAC      = 16;
  localparam int ENT_W         = ENT_FRAC + 1;
  localparam int QUO_W         = ENT_W + 1;
  localparam int DIV_W         = PROD_W + QUO_W;
  localparam int STEP_W        = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [ENT_W-1:0] ENT_ONE   = ENT_W'(1) << ENT_FRAC;

  typedef struct packed {
    logic signed [PRICE_W-1:0] price;
    logic                      price_missing;
    logic                      series_end;
  } sample_t;

  typedef struct packed {
    logic [ENT_W-1:0] entropy;
    logic             entropy_defined;
  } result_t;

endpackage

FILE: rtl/core/return_sign_entropy_core.sv
`timescale 1ns / 1ps

// sample beats without series_end leave sample_ready high
// a series_end beat holds sample_ready low for the finalize, which also waits for
// result_ready while an earlier result is still pending
// the finalize uses one shared 31x31 multiplier (16 squarings per log2, up to five
// logs) and an 18-step restoring divider
// rst is synchronous active high: counts and previous sample cleared, no result pending
module return_sign_entropy_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  rse_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output rse_pkg::result_t result
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_KCHK = 4'd1;
  localparam logic [3:0] ST_LOGI = 4'd2;
  localparam logic [3:0] ST_LOGS = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_DEN  = 4'd6;
  localparam logic [3:0] ST_NUM  = 4'd7;
  localparam logic [3:0] ST_SAT  = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam logic [2:0] OP_DOWN  = 3'd0;
  localparam logic [2:0] OP_FLAT  = 3'd1;
  localparam logic [2:0] OP_UP    = 3'd2;
  localparam logic [2:0] OP_TOTAL = 3'd3;
  localparam logic [2:0] OP_THREE = 3'd4;

  logic [3:0]                           state;
  logic signed [rse_pkg::PRICE_W-1:0]   prev_price;
  logic                                 prev_missing;
  logic                                 have_prev;
  logic [rse_pkg::CNT_W-1:0]            down_count;
  logic [rse_pkg::CNT_W-1:0]            flat_count;
  logic [rse_pkg::CNT_W-1:0]            up_count;

  logic [2:0]                           idx;
  logic [1:0]                           kcnt;
  logic                                 defined;
  logic [rse_pkg::STEP_W-1:0]           step;
  logic [rse_pkg::EXP_W-1:0]            exp_r;
  logic [rse_pkg::LOG_FRAC_BITS-1:0]    frac;
  logic [rse_pkg::MANT_W-1:0]           mant;
  logic [rse_pkg::PROD_W-1:0]           prod;
  logic [rse_pkg::SUM_W-1:0]            sum;
  logic [rse_pkg::PROD_W-1:0]           whole;
  logic [rse_pkg::LOG_W-1:0]            lk;
  logic [rse_pkg::PROD_W-1:0]           den;
  logic [rse_pkg::DIV_W-1:0]            rem;
  logic [rse_pkg::DIV_W-1:0]            dsh;
  logic [rse_pkg::QUO_W-1:0]            quo;

  logic                                 pair_ok;
  logic                                 cur_gt;
  logic                                 cur_lt;
  logic                                 is_up;
  logic                                 is_down;
  logic [rse_pkg::TOT_W-1:0]            total;
  logic [1:0]                           kc;
  logic [rse_pkg::TOT_W-1:0]            x_sel;
  logic [rse_pkg::EXP_W-1:0]            x_exp;
  logic [rse_pkg::MUL_W-1:0]            mul_a;
  logic [rse_pkg::MUL_W-1:0]            mul_b;
  logic [2*rse_pkg::MUL_W-1:0]          mul_p;
  logic [rse_pkg::MANT_W:0]             sq;
  logic [rse_pkg::LOG_FRAC_BITS-1:0]    frac_next;
  logic [rse_pkg::SUM_W-1:0]            diff;
  logic [rse_pkg::PROD_W-1:0]           num;
  logic                                 div_ge;
  logic [rse_pkg::ENT_W-1:0]            ent;

  assign sample_ready = (state == ST_IDLE);

  // sign of the return times sign of the previous price
  assign pair_ok = have_prev && !prev_missing && !sample.price_missing && (prev_price != '0);
  assign cur_gt  = sample.price > prev_price;
  assign cur_lt  = sample.price < prev_price;
  assign is_up   = prev_price[rse_pkg::PRICE_W-1] ? cur_lt : cur_gt;
  assign is_down = prev_price[rse_pkg::PRICE_W-1] ? cur_gt : cur_lt;

  assign total = rse_pkg::TOT_W'(down_count) + rse_pkg::TOT_W'(flat_count)
               + rse_pkg::TOT_W'(up_count);
  assign kc = 2'(down_count != '0) + 2'(flat_count != '0) + 2'(up_count != '0);

  always_comb begin
    unique case (idx)
      OP_DOWN:  x_sel = rse_pkg::TOT_W'(down_count);
      OP_FLAT:  x_sel = rse_pkg::TOT_W'(flat_count);
      OP_UP:    x_sel = rse_pkg::TOT_W'(up_count);
      OP_TOTAL: x_sel = total;
      default:  x_sel = rse_pkg::TOT_W'(3);
    endcase
  end

  // integer part of log2: index of the leading one
  always_comb begin
    x_exp = '0;
    for (int i = 0; i < rse_pkg::TOT_W; i++) begin
      if (x_sel[i]) x_exp = rse_pkg::EXP_W'(i);
    end
  end

  // shared multiplier
  always_comb begin
    unique case (state)
      ST_MUL: begin
        mul_a = rse_pkg::MUL_W'(x_sel);
        mul_b = rse_pkg::MUL_W'({exp_r, frac});
      end
      ST_DEN: begin
        mul_a = rse_pkg::MUL_W'(total);
        mul_b = rse_pkg::MUL_W'(lk);
      end
      default: begin
        mul_a = mant;
        mul_b = mant;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign sq        = mul_p[rse_pkg::MANT_BITS +: rse_pkg::MANT_W + 1];
  assign frac_next = {frac[rse_pkg::LOG_FRAC_BITS-2:0], sq[rse_pkg::MANT_W]};

  assign diff   = rse_pkg::SUM_W'(whole) - sum;
  assign num    = diff[rse_pkg::SUM_W-1] ? '0 : diff[rse_pkg::PROD_W-1:0];
  assign div_ge = rem >= dsh;
  assign ent    = (quo > rse_pkg::QUO_W'(rse_pkg::ENT_ONE)) ? rse_pkg::ENT_ONE
                : quo[rse_pkg::ENT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      prev_price   <= '0;
      prev_missing <= 1'b1;
      have_prev    <= 1'b0;
      down_count   <= '0;
      flat_count   <= '0;
      up_count     <= '0;
    end else begin
      if (result_valid && result_ready && (state != ST_DONE)) result_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            if (pair_ok) begin
              if (is_up) begin
                if (up_count != rse_pkg::COUNT_MAX) up_count <= up_count + 1'b1;
              end else if (is_down) begin
                if (down_count != rse_pkg::COUNT_MAX) down_count <= down_count + 1'b1;
              end else begin
                if (flat_count != rse_pkg::COUNT_MAX) flat_count <= flat_count + 1'b1;
              end
            end
            prev_price   <= sample.price;
            prev_missing <= sample.price_missing;
            have_prev    <= 1'b1;
            if (sample.series_end) state <= ST_KCHK;
          end
        end
        ST_KCHK: begin
          if (kc < 2'd2) begin
            defined <= 1'b0;
            quo     <= '0;
            state   <= ST_DONE;
          end else begin
            defined <= 1'b1;
            kcnt    <= kc;
            idx     <= OP_DOWN;
            sum     <= '0;
            state   <= ST_LOGI;
          end
        end
        ST_LOGI: begin
          exp_r <= x_exp;
          frac  <= '0;
          mant  <= rse_pkg::MANT_W'(x_sel) << (rse_pkg::EXP_W'(rse_pkg::MANT_BITS) - x_exp);
          step  <= rse_pkg::STEP_W'(rse_pkg::LOG_FRAC_BITS - 1);
          state <= ST_LOGS;
        end
        ST_LOGS: begin
          // square the mantissa, take a bit when it reaches 2.0
          frac <= frac_next;
          mant <= sq[rse_pkg::MANT_W] ? sq[rse_pkg::MANT_W:1] : sq[rse_pkg::MANT_W-1:0];
          step <= step - 1'b1;
          if (step == '0) begin
            if (idx == OP_THREE) begin
              lk    <= {exp_r, frac_next};
              state <= ST_DEN;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod  <= mul_p[rse_pkg::PROD_W-1:0];
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (idx == OP_TOTAL) begin
            whole <= prod;
            if (kcnt == 2'd3) begin
              idx   <= OP_THREE;
              state <= ST_LOGI;
            end else begin
              lk    <= rse_pkg::LOG_W'(1) << rse_pkg::LOG_FRAC_BITS;
              state <= ST_DEN;
            end
          end else begin
            sum   <= sum + rse_pkg::SUM_W'(prod);
            idx   <= idx + 1'b1;
            state <= ST_LOGI;
          end
        end
        ST_DEN: begin
          den   <= mul_p[rse_pkg::PROD_W-1:0];
          state <= ST_NUM;
        end
        ST_NUM: begin
          rem   <= rse_pkg::DIV_W'({num, {rse_pkg::ENT_FRAC{1'b0}}});
          state <= ST_SAT;
        end
        ST_SAT: begin
          // quotient too large for the divider width saturates outright
          if (rem >= {den, {rse_pkg::QUO_W{1'b0}}}) begin
            quo   <= rse_pkg::QUO_W'(rse_pkg::ENT_ONE);
            state <= ST_DONE;
          end else begin
            quo   <= '0;
            dsh   <= {1'b0, den, {(rse_pkg::QUO_W-1){1'b0}}};
            step  <= rse_pkg::STEP_W'(rse_pkg::QUO_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) rem <= rem - dsh;
          quo  <= {quo[rse_pkg::QUO_W-2:0], div_ge};
          dsh  <= dsh >> 1;
          step <= step - 1'b1;
          if (step == '0) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid           <= 1'b1;
            result.entropy         <= ent;
            result.entropy_defined <= defined;
            prev_price             <= '0;
            prev_missing           <= 1'b1;
            have_prev              <= 1'b0;
            down_count             <= '0;
            flat_count             <= '0;
            up_count               <= '0;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.entropy_defined |-> result.entropy == '0)
    else $error("undefined entropy result carries a nonzero value");

  a_ent_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.entropy <= rse_pkg::ENT_ONE)
    else $error("entropy above 1.0");

  a_plain_beat: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && !sample.series_end |=> state == ST_IDLE)
    else $error("finalize started without series end");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> {1'b0, rem} < {dsh, 1'b0})
    else $error("divider remainder out of range");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  rse_pkg::sample_t smp_beat = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  rse_pkg::result_t res_beat;

  return_sign_entropy_core u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (smp_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (res_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sign-count tracker: mirror of the series state
  logic signed [rse_pkg::PRICE_W-1:0] prev_px   = '0;
  logic                               prev_miss = 1'b1;
  logic                               have_prev = 1'b0;
  logic [rse_pkg::CNT_W-1:0]          n_down    = '0;
  logic [rse_pkg::CNT_W-1:0]          n_flat    = '0;
  logic [rse_pkg::CNT_W-1:0]          n_up      = '0;

  rse_pkg::result_t entropy_expected[$];
  int               mismatches = 0;
  int               samples_sent = 0;

  // sender pacing and receiver hold-off control
  int burst_left = 0;
  int gap_max    = 6;
  bit hold_req   = 1'b0;
  int hold_len   = 0;

  function automatic longint unsigned log2_q16(input longint unsigned x);
    int              e;
    longint unsigned t;
    longint unsigned m;
    longint unsigned r;
    if (x == 0) return 0;
    e = 0;
    t = x;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    if (e <= rse_pkg::MANT_BITS) m = x << (rse_pkg::MANT_BITS - e);
    else m = x >> (e - rse_pkg::MANT_BITS);
    r = longint'(e) << rse_pkg::LOG_FRAC_BITS;
    // one fraction bit per squaring of the mantissa, truncating
    for (int i = rse_pkg::LOG_FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> rse_pkg::MANT_BITS;
      if (m >= (64'd1 << (rse_pkg::MANT_BITS + 1))) begin
        r |= 64'd1 << i;
        m >>= 1;
      end
    end
    return r;
  endfunction

  function automatic rse_pkg::result_t entropy_of_counts();
    longint unsigned  c[3];
    longint unsigned  total;
    longint unsigned  sum;
    longint unsigned  whole;
    longint unsigned  lk;
    longint unsigned  den;
    longint unsigned  q;
    longint           num;
    int               k;
    rse_pkg::result_t res;
    c[0] = n_down;
    c[1] = n_flat;
    c[2] = n_up;
    total = c[0] + c[1] + c[2];
    sum = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      if (c[i] > 0) begin
        k++;
        sum += c[i] * log2_q16(c[i]);
      end
    end
    res = '0;
    if (k >= 2 && total != 0) begin
      whole = total * log2_q16(total);
      num = longint'(whole) - longint'(sum);
      if (num < 0) num = 0;
      lk = (k == 2) ? (64'd1 << rse_pkg::LOG_FRAC_BITS) : log2_q16(3);
      den = total * lk;
      q = (unsigned'(num) << rse_pkg::ENT_FRAC) / den;
      if (q > rse_pkg::ENT_ONE) q = rse_pkg::ENT_ONE;
      res.entropy = q[rse_pkg::ENT_W-1:0];
      res.entropy_defined = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [rse_pkg::CNT_W-1:0] sat_inc(input logic [rse_pkg::CNT_W-1:0] n);
    return (n == rse_pkg::COUNT_MAX) ? n : n + 1'b1;
  endfunction

  task automatic track_sample(input rse_pkg::sample_t s);
    longint cur;
    longint prv;
    longint d;
    int     sd;
    int     sp;
    cur = s.price;
    prv = prev_px;
    if (have_prev && !prev_miss && !s.price_missing && prev_px != 0) begin
      d = cur - prv;
      sd = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
      sp = (prv > 0) ? 1 : -1;
      if (sd * sp > 0) n_up = sat_inc(n_up);
      else if (sd * sp < 0) n_down = sat_inc(n_down);
      else n_flat = sat_inc(n_flat);
    end
    prev_px = s.price;
    prev_miss = s.price_missing;
    have_prev = 1'b1;
    if (s.series_end) begin
      entropy_expected.push_back(entropy_of_counts());
      prev_px = '0;
      prev_miss = 1'b1;
      have_prev = 1'b0;
      n_down = '0;
      n_flat = '0;
      n_up = '0;
    end
  endtask

  // called and returns at a falling edge; valid stays high across a burst
  task automatic send_sample(input rse_pkg::sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    smp_beat <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    track_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_px(input logic signed [rse_pkg::PRICE_W-1:0] px, input logic miss,
                         input logic last);
    rse_pkg::sample_t s;
    s.price = px;
    s.price_missing = miss;
    s.series_end = last;
    send_sample(s);
  endtask

  // flavor 0: random walk around a base, 1: any price, 2: near zero
  task automatic send_series(input int len, input int flavor);
    logic signed [rse_pkg::PRICE_W-1:0] base;
    logic signed [rse_pkg::PRICE_W-1:0] px;
    base = $urandom;
    for (int i = 0; i < len; i++) begin
      case (flavor)
        0: px = base + $urandom_range(0, 4) - 2;
        1: px = $urandom;
        default: px = $signed($urandom_range(0, 4)) - 2;
      endcase
      if (flavor == 0) base = px;
      send_px(px, $urandom_range(0, 9) == 0, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // lone sample: no pair at all
    send_px(32'sh7FFF_FFFF, 1'b0, 1'b1);
    // up, flat, down
    send_px(100, 1'b0, 1'b0);
    send_px(200, 1'b0, 1'b0);
    send_px(200, 1'b0, 1'b0);
    send_px(150, 1'b0, 1'b1);
    // full-scale swings, then a missing sample breaking the chain
    send_px(32'sh8000_0000, 1'b0, 1'b0);
    send_px(32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_px(32'sh8000_0000, 1'b0, 1'b0);
    send_px($urandom, 1'b1, 1'b0);
    send_px(5, 1'b0, 1'b0);
    send_px(7, 1'b0, 1'b1);
    // zero previous price, negative previous flips the sign
    send_px(0, 1'b0, 1'b0);
    send_px(10, 1'b0, 1'b0);
    send_px(-10, 1'b0, 1'b0);
    send_px(-20, 1'b0, 1'b0);
    send_px(-20, 1'b0, 1'b1);
    // a single occupied bin
    send_px(3, 1'b0, 1'b0);
    send_px(3, 1'b0, 1'b0);
    send_px(3, 1'b0, 1'b1);
    // missing samples only
    send_px($urandom, 1'b1, 1'b0);
    send_px($urandom, 1'b1, 1'b1);
    // missing on the closing sample
    send_px(4, 1'b0, 1'b0);
    send_px(6, 1'b0, 1'b0);
    send_px(5, 1'b1, 1'b1);
  endtask

  task automatic test_random_series();
    int stop_at;
    int len;
    stop_at = samples_sent + 600;
    while (samples_sent < stop_at) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send_series(len, ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(0, 2));
    end
  endtask

  task automatic test_backpressure();
    int saved_gap;
    saved_gap = gap_max;
    gap_max = 0;
    hold_len = 400;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_series($urandom_range(2, 4), i % 3);
    gap_max = saved_gap;
  endtask

  // result side: switches between stall patterns, honors a long hold-off
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_req) begin
        hold_left = hold_len;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= (phase % 7) < 3;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (entropy_expected.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got entropy %0d defined %0b",
                 $time, res_beat.entropy, res_beat.entropy_defined);
        mismatches++;
      end else begin
        if (res_beat.entropy !== entropy_expected[0].entropy) begin
          $display("%0t: entropy mismatch, expected %0d, got %0d", $time,
                   entropy_expected[0].entropy, res_beat.entropy);
          mismatches++;
        end
        if (res_beat.entropy_defined !== entropy_expected[0].entropy_defined) begin
          $display("%0t: entropy_defined mismatch, expected %0b, got %0b", $time,
                   entropy_expected[0].entropy_defined, res_beat.entropy_defined);
          mismatches++;
        end
        void'(entropy_expected.pop_front());
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_series();
    test_backpressure();

    sample_valid <= 1'b0;
    waited = 0;
    while (entropy_expected.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // room for a stray result after the last finalize
    repeat (300) @(posedge clk);
    if (entropy_expected.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, entropy_expected.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
